// ----- hw/rtl/v3alu_pkg.sv -----
// Shared types, constants and saturation helpers for the vector ALU.
`default_nettype none

package v3alu_pkg;

    localparam int W = 32;
    localparam int F = 16;
    localparam int N = W + F;

    typedef enum logic [2:0] {
        CMD_MAG   = 3'd0,
        CMD_NORM  = 3'd1,
        CMD_SCALE = 3'd2,
        CMD_DIV   = 3'd3,
        CMD_NEG   = 3'd4,
        CMD_ADD   = 3'd5,
        CMD_SUB   = 3'd6,
        CMD_EQ    = 3'd7
    } cmd_t;

    typedef struct packed {
        logic [2:0]          cmd;
        logic signed [W-1:0] a_x;
        logic signed [W-1:0] a_y;
        logic signed [W-1:0] a_z;
        logic signed [W-1:0] b_x;
        logic signed [W-1:0] b_y;
        logic signed [W-1:0] b_z;
        logic signed [W-1:0] scalar;
    } op_word_t;

    typedef struct packed {
        logic signed [W-1:0] r_x;
        logic signed [W-1:0] r_y;
        logic signed [W-1:0] r_z;
        logic [W-1:0]        magnitude;
        logic                equal;
        logic                fault;
    } res_word_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [2:0]          neg_a;
        logic                neg_s;
        logic                eq;
        logic [2:0][W-1:0]   abs_a;
        logic [W-1:0]        abs_s;
        logic [2:0][W-1:0]   early_r;
    } side_t;

    typedef struct packed {
        side_t               side;
        logic [2*W-1:0]      rad;
        logic [W:0]          rem;
        logic [W-1:0]        root;
    } sqrt_t;

    typedef struct packed {
        side_t               side;
        logic [W-1:0]        mag;
        logic [W-1:0]        dvs;
        logic                fault;
        logic [2:0][N-1:0]   num;
        logic [2:0][N-1:0]   quo;
        logic [2:0][W-1:0]   rem;
    } div_t;

    function automatic logic [W-1:0] sat_add(logic [W:0] v);
        if (v[W] != v[W-1])
        begin
            return v[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        return v[W-1:0];
    endfunction

    function automatic logic [W-1:0] sat_mag(logic [2*W-1:0] q, logic neg);
        logic [2*W-1:0] lim;
        logic [W-1:0]   m;
        lim = {{W{1'b0}}, neg, {(W-1){~neg}}};
        m = (q > lim) ? lim[W-1:0] : q[W-1:0];
        return neg ? (~m + {{(W-1){1'b0}}, 1'b1}) : m;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/v3alu_front.sv -----
// Front stages: absolute values, squares, scale products and simple vector results.
`default_nettype none

module v3alu_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire v3alu_pkg::op_word_t  op,
    output logic                      out_valid,
    output v3alu_pkg::sqrt_t          out_data
);

    localparam int W = v3alu_pkg::W;
    localparam int F = v3alu_pkg::F;

    logic                  s1_valid_reg;
    v3alu_pkg::side_t      s1_side_reg;
    v3alu_pkg::side_t      s1_side_next;
    logic [2:0][2*W-1:0]   sq_reg;
    logic [2:0][2*W-1:0]   sq_next;
    logic [2:0][2*W-1:0]   prod_reg;
    logic [2:0][2*W-1:0]   prod_next;
    logic                  s2_valid_reg;
    v3alu_pkg::sqrt_t      s2_reg;
    v3alu_pkg::sqrt_t      s2_next;
    logic [2:0][W-1:0]     av;
    logic [2:0][W-1:0]     bv;
    logic [W:0]            ea;
    logic [W:0]            eb;

    always_comb
    begin
        av = {op.a_z, op.a_y, op.a_x};
        bv = {op.b_z, op.b_y, op.b_x};
        s1_side_next.cmd = v3alu_pkg::cmd_t'(op.cmd);
        s1_side_next.neg_s = op.scalar[W-1];
        s1_side_next.abs_s = op.scalar[W-1] ? (~op.scalar + 1'b1) : op.scalar;
        s1_side_next.eq = (op.a_x == op.b_x) && (op.a_y == op.b_y) && (op.a_z == op.b_z);
        for (int i = 0; i < 3; i++)
        begin
            ea = {av[i][W-1], av[i]};
            eb = {bv[i][W-1], bv[i]};
            s1_side_next.neg_a[i] = av[i][W-1];
            s1_side_next.abs_a[i] = av[i][W-1] ? (~av[i] + 1'b1) : av[i];
            sq_next[i] = (2*W)'(s1_side_next.abs_a[i]) * (2*W)'(s1_side_next.abs_a[i]);
            prod_next[i] = (2*W)'(s1_side_next.abs_a[i]) * (2*W)'(s1_side_next.abs_s);
            case (v3alu_pkg::cmd_t'(op.cmd))
                v3alu_pkg::CMD_NEG: s1_side_next.early_r[i] = v3alu_pkg::sat_add(~ea + 1'b1);
                v3alu_pkg::CMD_ADD: s1_side_next.early_r[i] = v3alu_pkg::sat_add(ea + eb);
                v3alu_pkg::CMD_SUB: s1_side_next.early_r[i] = v3alu_pkg::sat_add(ea - eb);
                default:            s1_side_next.early_r[i] = '0;
            endcase
        end
    end

    always_comb
    begin
        s2_next.side = s1_side_reg;
        s2_next.rad = sq_reg[0] + sq_reg[1] + sq_reg[2];
        s2_next.rem = '0;
        s2_next.root = '0;
        if (s1_side_reg.cmd == v3alu_pkg::CMD_SCALE)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s2_next.side.early_r[i] = v3alu_pkg::sat_mag(prod_reg[i] >> F,
                    s1_side_reg.neg_a[i] ^ s1_side_reg.neg_s);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg <= s1_side_next;
            sq_reg <= sq_next;
            prod_reg <= prod_next;
            s2_reg <= s2_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data = s2_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/v3alu_sqrt_cell.sv -----
// One cell of the square root chain: settles one bit of the root.
`default_nettype none

module v3alu_sqrt_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire v3alu_pkg::sqrt_t  in_data,
    output logic                   out_valid,
    output v3alu_pkg::sqrt_t       out_data
);

    localparam int W = v3alu_pkg::W;

    logic              valid_reg;
    v3alu_pkg::sqrt_t  data_reg;
    v3alu_pkg::sqrt_t  data_next;
    logic [W+2:0]      acc;
    logic [W+2:0]      trial;
    logic [W+2:0]      diff;

    always_comb
    begin
        acc = {in_data.rem, in_data.rad[2*W-1:2*W-2]};
        trial = {1'b0, in_data.root, 2'b01};
        diff = acc - trial;
        data_next.side = in_data.side;
        data_next.rad = {in_data.rad[2*W-3:0], 2'b00};
        if (acc >= trial)
        begin
            data_next.rem = diff[W:0];
            data_next.root = {in_data.root[W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem = acc[W:0];
            data_next.root = {in_data.root[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/v3alu_div_cell.sv -----
// One cell of the divider chain: settles one quotient bit in each of three lanes.
`default_nettype none

module v3alu_div_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire v3alu_pkg::div_t  in_data,
    output logic                  out_valid,
    output v3alu_pkg::div_t       out_data
);

    localparam int W = v3alu_pkg::W;
    localparam int N = v3alu_pkg::N;

    logic             valid_reg;
    v3alu_pkg::div_t  data_reg;
    v3alu_pkg::div_t  data_next;
    logic [W:0]       r2;
    logic [W:0]       dd;
    logic [W:0]       diff;

    always_comb
    begin
        data_next = in_data;
        dd = {1'b0, in_data.dvs};
        for (int i = 0; i < 3; i++)
        begin
            r2 = {in_data.rem[i], in_data.num[i][N-1]};
            diff = r2 - dd;
            data_next.num[i] = {in_data.num[i][N-2:0], 1'b0};
            if (r2 >= dd)
            begin
                data_next.rem[i] = diff[W-1:0];
                data_next.quo[i] = {in_data.quo[i][N-2:0], 1'b1};
            end
            else
            begin
                data_next.rem[i] = r2[W-1:0];
                data_next.quo[i] = {in_data.quo[i][N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/vector3_fixed_point_alu.sv -----
// Top level of the three-component signed fixed-point vector ALU.
// The block takes one word per cycle unless the chain holds, and returns one result
// word for each, in order. At Q16.16 a word passes two front stages for squares and
// products, one chain cell per root bit, one divider cell per quotient bit and an
// output register. The whole chain advances together; it holds while a result sits
// unclaimed at the output, and a new word is taken in the cycle that result leaves.
`default_nettype none

module vector3_fixed_point_alu (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  op_valid,
    output logic                       op_stall,
    input  wire v3alu_pkg::op_word_t   op,
    output logic                       res_valid,
    input  wire logic                  res_stall,
    output v3alu_pkg::res_word_t       res
);

    localparam int W = v3alu_pkg::W;
    localparam int F = v3alu_pkg::F;
    localparam int N = v3alu_pkg::N;

    logic                   en;
    logic                   sq_valid [0:W];
    v3alu_pkg::sqrt_t       sq_data  [0:W];
    logic                   dv_valid [0:N];
    v3alu_pkg::div_t        dv_data  [0:N];
    logic                   res_valid_reg;
    v3alu_pkg::res_word_t   res_reg;
    v3alu_pkg::res_word_t   res_next;
    v3alu_pkg::side_t       ls;
    logic [2:0][W-1:0]      rr;
    logic                   neg;

    assign en = !res_valid_reg || !res_stall;
    assign op_stall = !en;

    v3alu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (op_valid),
        .op        (op),
        .out_valid (sq_valid[0]),
        .out_data  (sq_data[0])
    );

    for (genvar k = 0; k < W; k++)
    begin : g_sqrt
        v3alu_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_valid[k]),
            .in_data   (sq_data[k]),
            .out_valid (sq_valid[k+1]),
            .out_data  (sq_data[k+1])
        );
    end

    always_comb
    begin
        dv_valid[0] = sq_valid[W];
        dv_data[0].side = sq_data[W].side;
        dv_data[0].mag = sq_data[W].root;
        dv_data[0].dvs = (sq_data[W].side.cmd == v3alu_pkg::CMD_NORM) ?
                         sq_data[W].root : sq_data[W].side.abs_s;
        dv_data[0].fault = ((sq_data[W].side.cmd == v3alu_pkg::CMD_NORM) &&
                            (sq_data[W].root == '0)) ||
                           ((sq_data[W].side.cmd == v3alu_pkg::CMD_DIV) &&
                            (sq_data[W].side.abs_s == '0));
        for (int i = 0; i < 3; i++)
        begin
            dv_data[0].num[i] = {sq_data[W].side.abs_a[i], {F{1'b0}}};
            dv_data[0].quo[i] = '0;
            dv_data[0].rem[i] = '0;
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_div
        v3alu_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_valid[k]),
            .in_data   (dv_data[k]),
            .out_valid (dv_valid[k+1]),
            .out_data  (dv_data[k+1])
        );
    end

    always_comb
    begin
        ls = dv_data[N].side;
        for (int i = 0; i < 3; i++)
        begin
            neg = ls.neg_a[i] ^ ((ls.cmd == v3alu_pkg::CMD_DIV) && ls.neg_s);
            if (dv_data[N].fault)
            begin
                rr[i] = '0;
            end
            else if ((ls.cmd == v3alu_pkg::CMD_NORM) || (ls.cmd == v3alu_pkg::CMD_DIV))
            begin
                rr[i] = v3alu_pkg::sat_mag((2*W)'(dv_data[N].quo[i]), neg);
            end
            else
            begin
                rr[i] = ls.early_r[i];
            end
        end
        res_next.r_x = $signed(rr[0]);
        res_next.r_y = $signed(rr[1]);
        res_next.r_z = $signed(rr[2]);
        res_next.magnitude = dv_data[N].mag;
        res_next.equal = ls.eq;
        res_next.fault = dv_data[N].fault;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= dv_valid[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res = res_reg;

endmodule

`default_nettype wire
